[src/assert_macros.svh]
// Assertion macros shared by the accumulator and decision modules of the silence segmenter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

[src/rss_pkg.sv]
// Types and constants shared by the RMS silence segmenter modules.
package rss_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SQ_W     = 33;
    localparam int ENERGY_W = 48;
    localparam int THR_W    = 17;
    localparam int TSQ_W    = 34;
    localparam int RUN_W    = 17;
    localparam int SEG_W    = 16;
    localparam int FMT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Sample formats
    localparam logic [FMT_W-1:0] FMT_S16 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_S32 = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SILENT_FRAMES = 2'd2;

    localparam logic [THR_W-1:0] THR_UNITY = 17'd65536;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       has_sample;
        logic                       frame_end;
        logic                       stream_end;
    } in_t;

    typedef struct packed {
        logic             frame_silent;
        logic             close_segment;
        logic [SEG_W-1:0] frames_in_segment;
    } out_t;

    // Configuration as held by the block, with the threshold already squared.
    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic [TSQ_W-1:0] thr_sq;
        logic             thr_big;
        logic             thr_nz;
        logic [SEG_W-1:0] min_silent;
    } cfg_t;

    typedef struct packed {
        logic [SQ_W-1:0] sq;
        logic            has_sample;
        logic            frame_end;
        logic            stream_end;
    } sq_item_t;

    // Summary of a finished frame, handed from the accumulator to the decision stage.
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                empty;
        logic                stream_end;
    } frame_t;

endpackage

[src/rss_square.sv]
// Input register and squaring stage: normalises each sample to the energy unit.
module rss_square (
    input  logic             clk,
    input  logic             rst_n,
    input  rss_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  rss_pkg::in_t     in_data,
    output logic             sq_valid,
    input  logic             sq_ready,
    output rss_pkg::sq_item_t sq_item
);

    logic              a_valid_reg, a_valid_next;
    rss_pkg::in_t      a_data_reg;
    logic              b_valid_reg, b_valid_next;
    rss_pkg::sq_item_t b_data_reg, b_data_next;

    logic        b_free;
    logic        a_move;
    logic [31:0] ext;
    logic [31:0] mag;
    logic [63:0] prod;

    assign b_free   = !b_valid_reg || sq_ready;
    assign a_move   = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || a_move;
    assign sq_valid = b_valid_reg;
    assign sq_item  = b_data_reg;

    always_comb
    begin
        if (cfg.fmt == rss_pkg::FMT_S16)
        begin
            ext = {{16{a_data_reg.sample[15]}}, a_data_reg.sample[15:0]};
        end
        else
        begin
            ext = a_data_reg.sample;
        end
        mag  = ext[31] ? (32'd0 - ext) : ext;
        prod = {32'd0, mag} * {32'd0, mag};

        b_data_next.has_sample = a_data_reg.has_sample;
        b_data_next.frame_end  = a_data_reg.frame_end;
        b_data_next.stream_end = a_data_reg.stream_end;
        case (cfg.fmt)
            rss_pkg::FMT_S16: b_data_next.sq = {prod[30:0], 2'b00};
            rss_pkg::FMT_S32: b_data_next.sq = prod[62:30];
            default:          b_data_next.sq = '0;
        endcase
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_valid && in_ready)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (a_move)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_valid_reg && sq_ready)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_data_reg <= in_data;
        end
        if (a_move)
        begin
            b_data_reg <= b_data_next;
        end
    end

endmodule

[src/rss_accum.sv]
// Frame accumulator: saturating energy sum, sample count and threshold budget.
`include "assert_macros.svh"

module rss_accum #(
    parameter int MAX_FRAME_SAMPLES = 4096,
    parameter int CNT_W             = 13,
    parameter int LIM_W             = 47
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rss_pkg::cfg_t     cfg,
    input  logic              sq_valid,
    output logic              sq_ready,
    input  rss_pkg::sq_item_t sq_item,
    output logic              frame_valid,
    input  logic              frame_ready,
    output rss_pkg::frame_t   frame,
    output logic [LIM_W-1:0]  frame_budget
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_SAMPLES);

    logic [rss_pkg::ENERGY_W-1:0] energy_reg, energy_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [LIM_W-1:0]             limit_reg, limit_next;

    logic                         take;
    logic                         consume;
    logic [rss_pkg::ENERGY_W:0]   sum_wide;
    logic [rss_pkg::ENERGY_W-1:0] energy_upd;
    logic [CNT_W-1:0]             count_upd;
    logic [LIM_W-1:0]             limit_upd;

    // The threshold budget grows by t*t per counted sample, so at frame end
    // it equals t*t*count without a multiplier.
    always_comb
    begin
        take     = sq_item.has_sample && (count_reg < CNT_MAX);
        sum_wide = {1'b0, energy_reg} + {{(rss_pkg::ENERGY_W + 1 - rss_pkg::SQ_W){1'b0}},
                                         sq_item.sq};
        if (!take)
        begin
            energy_upd = energy_reg;
        end
        else if (sum_wide[rss_pkg::ENERGY_W])
        begin
            energy_upd = '1;
        end
        else
        begin
            energy_upd = sum_wide[rss_pkg::ENERGY_W-1:0];
        end
        count_upd = count_reg + CNT_W'(take);
        limit_upd = take ? (limit_reg + LIM_W'(cfg.thr_sq)) : limit_reg;
    end

    assign sq_ready          = !sq_item.frame_end || frame_ready;
    assign consume           = sq_valid && sq_ready;
    assign frame_valid       = sq_valid && sq_item.frame_end;
    assign frame.energy      = energy_upd;
    assign frame.empty       = (count_upd == '0);
    assign frame.stream_end  = sq_item.stream_end;
    assign frame_budget      = limit_upd;

    always_comb
    begin
        energy_next = energy_reg;
        count_next  = count_reg;
        limit_next  = limit_reg;
        if (consume)
        begin
            if (sq_item.frame_end)
            begin
                energy_next = '0;
                count_next  = '0;
                limit_next  = '0;
            end
            else
            begin
                energy_next = energy_upd;
                count_next  = count_upd;
                limit_next  = limit_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            count_reg  <= '0;
            limit_reg  <= '0;
        end
        else
        begin
            energy_reg <= energy_next;
            count_reg  <= count_next;
            limit_reg  <= limit_next;
        end
    end

    `ASSERT_IMPL(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CNT_MAX)
    `ASSERT_IMPL(a_empty_no_energy, clk, rst_n, frame_valid && frame.empty, frame.energy == '0)

endmodule

[src/rss_decide.sv]
// Silence decision, run and segment counters, and the result register.
`include "assert_macros.svh"

module rss_decide #(
    parameter int LIM_W = 47
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rss_pkg::cfg_t    cfg,
    input  logic             frame_valid,
    output logic             frame_ready,
    input  rss_pkg::frame_t  frame,
    input  logic [LIM_W-1:0] frame_budget,
    output logic             out_valid,
    input  logic             out_ready,
    output rss_pkg::out_t    out_data
);

    localparam int CMP_W = (LIM_W > rss_pkg::ENERGY_W) ? LIM_W : rss_pkg::ENERGY_W;

    logic                      c_valid_reg, c_valid_next;
    rss_pkg::frame_t           c_frame_reg;
    logic [LIM_W-1:0]          c_limit_reg;
    logic [rss_pkg::RUN_W-1:0] run_reg, run_next;
    logic [rss_pkg::SEG_W-1:0] seg_reg, seg_next;
    logic                      out_valid_reg, out_valid_next;
    rss_pkg::out_t             out_data_reg, out_data_next;

    logic                      free_out;
    logic                      c_move;
    logic                      c_load;
    logic                      unhandled;
    logic                      silent;
    logic                      close;
    logic [rss_pkg::RUN_W-1:0] run_upd;
    logic [rss_pkg::SEG_W-1:0] seg_upd;

    assign free_out    = !out_valid_reg || out_ready;
    assign c_move      = c_valid_reg && free_out;
    assign frame_ready = !c_valid_reg || c_move;
    assign c_load      = frame_valid && frame_ready;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;

    always_comb
    begin
        unhandled = !(cfg.fmt inside {rss_pkg::FMT_S16, rss_pkg::FMT_S32});
        if (unhandled)
        begin
            // An unhandled format counts as full-scale RMS.
            silent = cfg.thr_big;
        end
        else if (c_frame_reg.empty)
        begin
            silent = cfg.thr_nz;
        end
        else
        begin
            silent = CMP_W'(c_frame_reg.energy) < CMP_W'(c_limit_reg);
        end

        if (!silent)
        begin
            run_upd = '0;
        end
        else if (run_reg == '1)
        begin
            run_upd = run_reg;
        end
        else
        begin
            run_upd = run_reg + 1'b1;
        end

        seg_upd = (seg_reg == '1) ? seg_reg : (seg_reg + 1'b1);
        close   = (run_upd == {1'b0, cfg.min_silent}) || c_frame_reg.stream_end;

        out_data_next.frame_silent      = silent;
        out_data_next.close_segment     = close;
        out_data_next.frames_in_segment = seg_upd;
    end

    always_comb
    begin
        c_valid_next   = c_valid_reg;
        run_next       = run_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg;

        if (c_load)
        begin
            c_valid_next = 1'b1;
        end
        else if (c_move)
        begin
            c_valid_next = 1'b0;
        end

        if (c_move)
        begin
            run_next       = c_frame_reg.stream_end ? '0 : run_upd;
            seg_next       = close ? '0 : seg_upd;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            run_reg       <= '0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg   <= c_valid_next;
            run_reg       <= run_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_frame_reg <= frame;
            c_limit_reg <= frame_budget;
        end
        if (c_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `ASSERT_IMPL(a_result_counts_frame, clk, rst_n, out_valid_reg, out_data_reg.frames_in_segment != '0)
    `ASSERT_IMPL(a_loud_clears_run, clk, rst_n, out_valid_reg && !out_data_reg.frame_silent, run_reg == '0)
    `ASSERT_NEXT(a_close_restarts, clk, rst_n, c_move && close, seg_reg == '0)

endmodule

[src/rms_silence_segmenter.sv]
// RMS silence segmenter: top level with configuration registers.
//
// Takes one sample or frame-end mark per transfer and, for each frame-end
// transfer, returns one result: whether the frame's RMS fell below the
// threshold, whether the frame closes the current segment, and the segment's
// frame count so far. Items that do not end a frame produce no result. With
// the output side taking results freely, an item is accepted every cycle. A
// frame-end item passes the input register, the squared-sample register and
// the decision register, with the accumulator between the last two, before
// the decision logic loads the result register, which offers the frame's
// result. Each stage holds its own item, so the input keeps accepting while a
// result waits to be taken until the stages fill up. Configuration writes take
// effect at once and should be made while the block holds no item; writing
// the threshold squares it into a register there and then.
module rms_silence_segmenter #(
    parameter int MAX_FRAME_SAMPLES = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  rss_pkg::in_t                       in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output rss_pkg::out_t                      out_data
);

    localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int LIM_W = rss_pkg::TSQ_W + CNT_W;

    rss_pkg::cfg_t     cfg_reg, cfg_next;
    logic              sq_valid;
    logic              sq_ready;
    rss_pkg::sq_item_t sq_item;
    logic              frame_valid;
    logic              frame_ready;
    rss_pkg::frame_t   frame;
    logic [LIM_W-1:0]  frame_budget;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rss_pkg::CFG_SAMPLE_FORMAT:
                begin
                    cfg_next.fmt = cfg_data[rss_pkg::FMT_W-1:0];
                end
                rss_pkg::CFG_SILENCE_THRESHOLD:
                begin
                    cfg_next.thr_sq  = {{(rss_pkg::TSQ_W - rss_pkg::THR_W){1'b0}}, cfg_data}
                                     * {{(rss_pkg::TSQ_W - rss_pkg::THR_W){1'b0}}, cfg_data};
                    cfg_next.thr_big = cfg_data > rss_pkg::THR_UNITY;
                    cfg_next.thr_nz  = cfg_data != '0;
                end
                rss_pkg::CFG_MIN_SILENT_FRAMES:
                begin
                    cfg_next.min_silent = cfg_data[rss_pkg::SEG_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fmt        <= rss_pkg::FMT_S16;
            cfg_reg.thr_sq     <= '0;
            cfg_reg.thr_big    <= 1'b0;
            cfg_reg.thr_nz     <= 1'b0;
            cfg_reg.min_silent <= rss_pkg::SEG_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rss_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .sq_valid (sq_valid),
        .sq_ready (sq_ready),
        .sq_item  (sq_item)
    );

    rss_accum #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
        .CNT_W             (CNT_W),
        .LIM_W             (LIM_W)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sq_valid     (sq_valid),
        .sq_ready     (sq_ready),
        .sq_item      (sq_item),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .frame_budget (frame_budget)
    );

    rss_decide #(
        .LIM_W (LIM_W)
    ) u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .frame_budget (frame_budget),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule
